### src/wsd_pkg.sv
package wsd_pkg;

   // Width kept for the frame length counter; extended lengths wrap to it.
   localparam int LEN_BITS = 64;

   // Seven-bit length codes that select an extended length field
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Last byte index of each multi-byte header field
   localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
   localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
   localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

   // Entries in the queue between parser and output stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // One queued unit of work: a raw byte, its key byte and the frame tags
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
      logic       empty;
   } wsd_work_type;

endpackage

### src/wsd_front.sv
module wsd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_stream_byte,
   output logic                  push,
   output wsd_pkg::wsd_work_type push_work
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type                     phase_ff,   phase_in;
   logic [2:0]                    count_ff,   count_in;
   logic [3:0]                    opcode_ff,  opcode_in;
   logic                          fin_ff,     fin_in;
   logic                          masked_ff,  masked_in;
   logic [31:0]                   key_ff,     key_in;
   logic [wsd_pkg::LEN_BITS-1:0]  rem_ff,     rem_in;
   logic [1:0]                    kidx_ff,    kidx_in;

   logic                          accept;
   logic [wsd_pkg::LEN_BITS-1:0]  rem_shift;
   logic [31:0]                   key_shift;
   logic [7:0]                    key_sel;
   logic [2:0]                    ext_last;

   assign accept    = req_valid && !req_stall;
   assign rem_shift = {rem_ff[wsd_pkg::LEN_BITS-9:0], req_stream_byte};
   assign key_shift = {key_ff[23:0], req_stream_byte};
   assign ext_last  = (phase_ff == PH_EXT16) ? wsd_pkg::EXT16_LAST_IDX
                                             : wsd_pkg::EXT64_LAST_IDX;

   // Key byte 0 is the first key byte received, now in the top byte
   always_comb begin
      case (kidx_ff)
         2'd0:    key_sel = key_ff[31:24];
         2'd1:    key_sel = key_ff[23:16];
         2'd2:    key_sel = key_ff[15:8];
         default: key_sel = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      kidx_in   = kidx_ff;
      push      = 1'b0;
      push_work = '0;
      push_work.opcode = opcode_ff;
      push_work.fin    = fin_ff;
      case (phase_ff)
         PH_HDR0: begin
            fin_in    = req_stream_byte[7];
            opcode_in = req_stream_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            masked_in = req_stream_byte[7];
            key_in    = '0;
            count_in  = '0;
            if (req_stream_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               rem_in   = '0;
               phase_in = PH_EXT16;
            end else if (req_stream_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               rem_in   = '0;
               phase_in = PH_EXT64;
            end else begin
               rem_in = wsd_pkg::LEN_BITS'(req_stream_byte[6:0]);
               if (req_stream_byte[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  kidx_in = '0;
                  if (req_stream_byte[6:0] == 7'd0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     push_work.last  = 1'b1;
                     push_work.empty = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            rem_in = rem_shift;
            if (count_ff == ext_last) begin
               count_in = '0;
               if (masked_ff) begin
                  phase_in = PH_KEY;
               end else begin
                  kidx_in = '0;
                  if (rem_shift == '0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     push_work.last  = 1'b1;
                     push_work.empty = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = key_shift;
            if (count_ff >= wsd_pkg::KEY_LAST_IDX) begin
               count_in = '0;
               kidx_in  = '0;
               if (rem_ff == '0) begin
                  phase_in        = PH_HDR0;
                  push            = 1'b1;
                  push_work.last  = 1'b1;
                  push_work.empty = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            kidx_in            = kidx_ff + 2'd1;
            rem_in             = rem_ff - wsd_pkg::LEN_BITS'(1);
            push               = 1'b1;
            push_work.raw_byte = req_stream_byte;
            push_work.key_byte = masked_ff ? key_sel : 8'd0;
            if (rem_ff == wsd_pkg::LEN_BITS'(1)) begin
               push_work.last = 1'b1;
               phase_in       = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         count_ff  <= '0;
         opcode_ff <= '0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         key_ff    <= '0;
         rem_ff    <= '0;
         kidx_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         key_ff    <= key_in;
         rem_ff    <= rem_in;
         kidx_ff   <= kidx_in;
      end
   end

endmodule

### src/wsd_queue.sv
module wsd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wsd_pkg::wsd_work_type push_work,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output wsd_pkg::wsd_work_type head_work
);

   wsd_pkg::wsd_work_type                 slot_ff [wsd_pkg::QUEUE_DEPTH];
   logic [wsd_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wsd_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wsd_pkg::QUEUE_CNT_BITS-1:0]    count_ff,  count_in;
   logic                                  do_push;
   logic                                  do_pop;

   localparam logic [wsd_pkg::QUEUE_PTR_BITS-1:0] PTR_LAST =
      wsd_pkg::QUEUE_PTR_BITS'(wsd_pkg::QUEUE_DEPTH - 1);
   localparam logic [wsd_pkg::QUEUE_CNT_BITS-1:0] CNT_FULL =
      wsd_pkg::QUEUE_CNT_BITS'(wsd_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_work  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0
                                             : wr_ptr_ff + wsd_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0
                                             : rd_ptr_ff + wsd_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + wsd_pkg::QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - wsd_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

### src/wsd_back.sv
module wsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  wsd_pkg::wsd_work_type head_work,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_payload_byte,
   output logic [3:0]            rsp_frame_opcode,
   output logic                  rsp_final_fragment,
   output logic                  rsp_last_of_frame,
   output logic                  rsp_empty_frame
);

   logic       valid_ff;
   logic [7:0] byte_ff,  byte_in;
   logic [3:0] opcode_ff;
   logic       fin_ff;
   logic       last_ff;
   logic       empty_ff;
   logic       load;

   // Refill the output register when empty or being taken
   assign load    = !valid_ff || !rsp_stall;
   assign pop     = load && head_valid;
   assign byte_in = head_work.raw_byte ^ head_work.key_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= byte_in;
         opcode_ff <= head_work.opcode;
         fin_ff    <= head_work.fin;
         last_ff   <= head_work.last;
         empty_ff  <= head_work.empty;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_frame_opcode   = opcode_ff;
   assign rsp_final_fragment = fin_ff;
   assign rsp_last_of_frame  = last_ff;
   assign rsp_empty_frame    = empty_ff;

endmodule

### src/websocket_frame_deframer.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_stream_byte[7:0]
// rsp_      out        rsp_valid/rsp_stall  rsp_payload_byte[7:0], rsp_frame_opcode[3:0],
//                                           rsp_final_fragment, rsp_last_of_frame,
//                                           rsp_empty_frame
//
// One byte per cycle is taken while req_stall is low; the parser updates its header
// state at the edge that takes each byte. A payload byte or empty marker enters the
// two-entry work queue at the edge that takes its request and moves on into the output
// register, which drives rsp_valid, once that register is empty or being taken.
// Synchronous active-high reset clears the parser to await the first header byte and
// empties the queue and output register; no clearing pass is needed.
// req_stall rises only while the work queue is full; rsp_stall held against a loaded
// output register, with payload requests still flowing, is enough to fill it.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame
);

   logic                  push;
   wsd_pkg::wsd_work_type push_work;
   logic                  queue_full;
   logic                  head_valid;
   wsd_pkg::wsd_work_type head_work;
   logic                  pop;

   // Stall the request side only on a full queue, never on the response stall directly
   assign req_stall = queue_full;

   // Front: parse headers, track length and key, classify each byte
   wsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .push            (push),
      .push_work       (push_work)
   );

   // Queue: decouple the parser from the output handshake
   wsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_work  (push_work),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_work  (head_work)
   );

   // Back: unmask and hold the response in the output register
   wsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_work          (head_work),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

endmodule

### test/websocket_frame_deframer_checker.sv
module websocket_frame_deframer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_stream_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_payload_byte,
   input  logic [3:0] rsp_frame_opcode,
   input  logic       rsp_final_fragment,
   input  logic       rsp_last_of_frame,
   input  logic       rsp_empty_frame,
   output int         mismatch_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      AWAIT_FIN_OP,
      AWAIT_LENGTH,
      READ_EXT16,
      READ_EXT64,
      READ_KEY,
      PASS_PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       final_fragment;
      logic       last_of_frame;
      logic       empty_frame;
   } deframed_byte_type;

   localparam logic [63:0] LENGTH_MASK =
      (wsd_pkg::LEN_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                : ((64'd1 << wsd_pkg::LEN_BITS) - 64'd1);

   parse_phase_type   phase;
   logic [2:0]        field_idx;
   logic [3:0]        cur_opcode;
   logic              cur_fin;
   logic              cur_masked;
   logic [31:0]       cur_key;
   logic [63:0]       bytes_left;
   logic [1:0]        key_idx;
   deframed_byte_type expected_payload_q[$];
   int                mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t: ERROR %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   function automatic void emit_payload(logic [7:0] data, logic last, logic empty);
      deframed_byte_type item;
      item.payload_byte   = data;
      item.frame_opcode   = cur_opcode;
      item.final_fragment = cur_fin;
      item.last_of_frame  = last;
      item.empty_frame    = empty;
      expected_payload_q.push_back(item);
   endfunction

   // Length and key are known: either emit the empty marker or go to payload.
   function automatic void finish_header();
      bytes_left &= LENGTH_MASK;
      field_idx = '0;
      key_idx   = '0;
      if (bytes_left == 64'd0) begin
         phase = AWAIT_FIN_OP;
         emit_payload(8'h00, 1'b1, 1'b1);
      end else begin
         phase = PASS_PAYLOAD;
      end
   endfunction

   function automatic void finish_length();
      field_idx = '0;
      if (cur_masked) begin
         phase = READ_KEY;
      end else begin
         finish_header();
      end
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic [7:0] key_byte;
      case (phase)
         AWAIT_FIN_OP: begin
            cur_fin    = b[7];
            cur_opcode = b[3:0];
            phase      = AWAIT_LENGTH;
         end
         AWAIT_LENGTH: begin
            cur_masked = b[7];
            cur_key    = '0;
            field_idx  = '0;
            if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               bytes_left = '0;
               phase      = READ_EXT16;
            end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               bytes_left = '0;
               phase      = READ_EXT64;
            end else begin
               bytes_left = 64'(b[6:0]);
               finish_length();
            end
         end
         READ_EXT16, READ_EXT64: begin
            bytes_left = {bytes_left[55:0], b};
            if (field_idx == ((phase == READ_EXT16) ? wsd_pkg::EXT16_LAST_IDX
                                                    : wsd_pkg::EXT64_LAST_IDX)) begin
               finish_length();
            end else begin
               field_idx = field_idx + 3'd1;
            end
         end
         READ_KEY: begin
            cur_key = {cur_key[23:0], b};
            if (field_idx >= wsd_pkg::KEY_LAST_IDX) begin
               finish_header();
            end else begin
               field_idx = field_idx + 3'd1;
            end
         end
         PASS_PAYLOAD: begin
            // first key byte received applies to payload index 0
            key_byte   = cur_masked ? 8'(cur_key >> (24 - 8 * int'(key_idx))) : 8'h00;
            key_idx    = key_idx + 2'd1;
            bytes_left = bytes_left - 64'd1;
            if (bytes_left == 64'd0) begin
               phase = AWAIT_FIN_OP;
               emit_payload(b ^ key_byte, 1'b1, 1'b0);
            end else begin
               emit_payload(b ^ key_byte, 1'b0, 1'b0);
            end
         end
         default: begin
            phase = AWAIT_FIN_OP;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      deframed_byte_type want;
      if (reset) begin
         phase      = AWAIT_FIN_OP;
         field_idx  = '0;
         cur_opcode = '0;
         cur_fin    = 1'b0;
         cur_masked = 1'b0;
         cur_key    = '0;
         bytes_left = '0;
         key_idx    = '0;
         expected_payload_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_payload_q.size() == 0) begin
               report_mismatch("response with nothing pending, payload_byte",
                               rsp_payload_byte, 64'd0);
            end else begin
               want = expected_payload_q.pop_front();
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
               if (rsp_frame_opcode !== want.frame_opcode)
                  report_mismatch("frame_opcode", rsp_frame_opcode, want.frame_opcode);
               if (rsp_final_fragment !== want.final_fragment)
                  report_mismatch("final_fragment", rsp_final_fragment, want.final_fragment);
               if (rsp_last_of_frame !== want.last_of_frame)
                  report_mismatch("last_of_frame", rsp_last_of_frame, want.last_of_frame);
               if (rsp_empty_frame !== want.empty_frame)
                  report_mismatch("empty_frame", rsp_empty_frame, want.empty_frame);
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            deframe_byte(req_stream_byte);
      end
      pending_count <= expected_payload_q.size();
   end

endmodule

### test/websocket_frame_deframer_tb.sv
module websocket_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Forms of the frame length field
   typedef enum int {LEN_DIRECT, LEN_EXT16, LEN_EXT64} len_form_type;

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_stream_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;

   int mismatch_count;
   int pending_count;
   int sent_bytes  = 0;
   int calm_frames = 0;

   websocket_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

   // Watch both channels, predict every payload byte and compare.
   websocket_frame_deframer_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Idle length: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request byte and hold it until the block takes it. A valid that
   // stays high between back-to-back requests is never dropped and raised again.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (calm_frames > 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   // Drop valid and hold off until every predicted payload byte has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Send one frame: header, length field in the chosen form, key if masked,
   // then n_payload random payload bytes.
   task automatic put_frame(input logic [7:0] first_byte, input logic masked,
                            input len_form_type form, input logic [63:0] frame_len,
                            input int n_payload);
      send_byte(first_byte);
      case (form)
         LEN_DIRECT: begin
            send_byte({masked, frame_len[6:0]});
         end
         LEN_EXT16: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT16});
            for (int i = 1; i >= 0; i--)
               send_byte(frame_len[8*i +: 8]);
         end
         default: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT64});
            for (int i = 7; i >= 0; i--)
               send_byte(frame_len[8*i +: 8]);
         end
      endcase
      if (masked) begin
         for (int i = 0; i < 4; i++)
            send_byte(8'($urandom));
      end
      for (int i = 0; i < n_payload; i++)
         send_byte(8'($urandom));
   endtask

   // Random well-formed frame. Keep most payloads short so many headers go by;
   // extended lengths are mostly non-minimal, and zero lengths come up often.
   task automatic send_random_frame();
      int           roll;
      logic [63:0]  frame_len;
      len_form_type form;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         form      = LEN_DIRECT;
         frame_len = 64'($urandom_range(0, 8));
      end else if (roll < 65) begin
         form      = LEN_DIRECT;
         frame_len = ($urandom_range(0, 3) == 0) ? 64'd125 : 64'($urandom_range(9, 125));
      end else if (roll < 80) begin
         form      = LEN_EXT16;
         frame_len = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(126, 300))
                                                 : 64'($urandom_range(0, 12));
      end else begin
         form      = LEN_EXT64;
         frame_len = 64'($urandom_range(0, 12));
      end
      put_frame(8'($urandom), 1'($urandom), form, frame_len, int'(frame_len));
   endtask

   // Drive the result side's stall: calm stretches, short stalls and a few long ones.
   initial begin : rsp_stall_gen
      int hold;
      int run;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) < 2) begin
            hold = 0;
            run  = $urandom_range(20, 80);
         end else begin
            hold = pick_gap();
            run  = $urandom_range(1, 6);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [7:0] directed_stream[$];
      bit         paused_once;
      directed_stream = '{
         // zero-length frame, fin clear, opcode 0, unmasked: empty marker at once
         8'h00, 8'h00,
         // rsv bits set, fin set, opcode F, masked, zero length: marker after key
         8'hFF, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
         // binary frame, masked, three payload bytes, two of them at the byte extremes
         8'h82, 8'h83, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'h00, 8'hA5,
         // text frame, fin clear, with a non-minimal 16-bit length of one
         8'h01, 8'h7E, 8'h00, 8'h01, 8'h5A
      };
      paused_once = 1'b0;

      // Hold reset, then release it for good.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_stream[i])
         send_byte(directed_stream[i]);

      // Let the directed part drain completely before the random traffic.
      wait_for_drain();

      while (sent_bytes < 1400) begin
         // Now and then run a few frames back to back with no sender gaps.
         if (calm_frames == 0 && $urandom_range(0, 9) == 0)
            calm_frames = $urandom_range(3, 8);
         send_random_frame();
         if (calm_frames > 0)
            calm_frames--;
         if (!paused_once && sent_bytes > 700) begin
            wait_for_drain();
            paused_once = 1'b1;
         end
      end

      // Finish with a 64-bit length of all ones, top bit set: the frame never
      // completes, so only its first payload bytes go in.
      put_frame(8'h82, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 20);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Abort a hung run well past the slowest legal one.
   initial begin : watchdog
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
test/websocket_frame_deframer_checker.sv
test/websocket_frame_deframer_tb.sv
